// ===== rtl/rvdec_pkg.sv =====
package rvdec_pkg;

   // Major opcodes of the base integer set.
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   // Funct7 codes.
   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;

   // Exact system words.
   localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
   localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

   // Funct3 codes used in several groups.
   localparam logic [2:0] F3_0 = 3'd0;
   localparam logic [2:0] F3_1 = 3'd1;
   localparam logic [2:0] F3_2 = 3'd2;
   localparam logic [2:0] F3_3 = 3'd3;
   localparam logic [2:0] F3_4 = 3'd4;
   localparam logic [2:0] F3_5 = 3'd5;
   localparam logic [2:0] F3_6 = 3'd6;
   localparam logic [2:0] F3_7 = 3'd7;

   // Operation codes reported on the result channel.
   typedef enum logic [5:0] {
      OP_ILLEGAL = 6'd0,
      OP_LUI     = 6'd1,
      OP_AUIPC   = 6'd2,
      OP_JAL     = 6'd3,
      OP_JALR    = 6'd4,
      OP_BEQ     = 6'd5,
      OP_BNE     = 6'd6,
      OP_BLT     = 6'd7,
      OP_BGE     = 6'd8,
      OP_BLTU    = 6'd9,
      OP_BGEU    = 6'd10,
      OP_LB      = 6'd11,
      OP_LH      = 6'd12,
      OP_LW      = 6'd13,
      OP_LBU     = 6'd14,
      OP_LHU     = 6'd15,
      OP_SB      = 6'd16,
      OP_SH      = 6'd17,
      OP_SW      = 6'd18,
      OP_ADDI    = 6'd19,
      OP_SLTI    = 6'd20,
      OP_SLTIU   = 6'd21,
      OP_XORI    = 6'd22,
      OP_ORI     = 6'd23,
      OP_ANDI    = 6'd24,
      OP_SLLI    = 6'd25,
      OP_SRLI    = 6'd26,
      OP_SRAI    = 6'd27,
      OP_ADD     = 6'd28,
      OP_SUB     = 6'd29,
      OP_SLL     = 6'd30,
      OP_SLT     = 6'd31,
      OP_SLTU    = 6'd32,
      OP_XOR     = 6'd33,
      OP_SRL     = 6'd34,
      OP_SRA     = 6'd35,
      OP_OR      = 6'd36,
      OP_AND     = 6'd37,
      OP_ECALL   = 6'd38,
      OP_EBREAK  = 6'd39,
      OP_CSRRW   = 6'd40,
      OP_CSRRS   = 6'd41,
      OP_CSRRC   = 6'd42,
      OP_CSRRWI  = 6'd43,
      OP_CSRRSI  = 6'd44,
      OP_CSRRCI  = 6'd45
   } op_kind_type;

   // Request payload: one instruction word and its address.
   typedef struct packed {
      logic [31:0] instr_word;
      logic [31:0] instr_addr;
   } req_type;

   // Response payload: the decoded fields.
   typedef struct packed {
      op_kind_type        op_kind;
      logic [4:0]         dest_reg;
      logic [4:0]         src_reg_a;
      logic [4:0]         src_reg_b;
      logic signed [31:0] immediate;
      logic [11:0]        csr_number;
      logic [31:0]        target_addr;
   } rsp_type;

   // Format immediates, sign-extended to 32 bits.
   function automatic logic [31:0] imm_i(input logic [31:0] w);
      return {{20{w[31]}}, w[31:20]};
   endfunction

   function automatic logic [31:0] imm_s(input logic [31:0] w);
      return {{20{w[31]}}, w[31:25], w[11:7]};
   endfunction

   function automatic logic [31:0] imm_b(input logic [31:0] w);
      return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
   endfunction

   function automatic logic [31:0] imm_j(input logic [31:0] w);
      return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
   endfunction

endpackage

// ===== rtl/rv32i_instruction_decoder.sv =====
// RV32I instruction decoder.
//
// Request channel (req_valid, req_ready, req_payload) carries one instruction
// word and its address per transaction. Response channel (rsp_valid,
// rsp_ready, rsp_payload) carries the operation code, register numbers,
// immediate, CSR number and branch or jal target for that word.
//
// A transaction accepted at a clock edge is held in the input register,
// decoded by one level of logic, and its response is loaded into the output
// register when that register advances. Throughput is one transaction per
// cycle while the receiver does not stall, set by the single decode pass
// between the two registers; there is no loop or shared unit.
//
// Reset clears both valid flags, so the block holds no transaction and
// req_ready is high after reset. When the receiver stalls, the response is
// held unchanged and the input register still fills; with both registers
// full, req_ready drops until rsp_ready returns.
module rv32i_instruction_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rvdec_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rvdec_pkg::rsp_type rsp_payload
);
   import rvdec_pkg::*;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type decoded;
   logic    out_advance;
   logic    in_advance;

   // Each register moves when it is empty or its downstream side takes data.
   assign out_advance  = !out_valid_ff || rsp_ready;
   assign in_advance   = !in_valid_ff || out_advance;
   assign req_ready    = in_advance;
   assign in_valid_in  = in_advance ? req_valid : in_valid_ff;
   assign out_valid_in = out_advance ? in_valid_ff : out_valid_ff;

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load only when a transaction moves into them.
   always_ff @(posedge clock) begin
      if (in_advance && req_valid) begin
         in_data_ff <= req_payload;
      end
      if (out_advance && in_valid_ff) begin
         out_data_ff <= decoded;
      end
   end

   rvdec_decode u_decode (
      .instr_in   (in_data_ff),
      .result_out (decoded)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

// ===== rtl/rvdec_decode.sv =====
module rvdec_decode (
   input  rvdec_pkg::req_type instr_in,
   output rvdec_pkg::rsp_type result_out
);
   import rvdec_pkg::*;

   logic [31:0] w;
   logic [6:0]  opc;
   logic [4:0]  rd;
   logic [4:0]  rs1;
   logic [4:0]  rs2;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] target_sum;

   assign w   = instr_in.instr_word;
   assign opc = w[6:0];
   assign rd  = w[11:7];
   assign rs1 = w[19:15];
   assign rs2 = w[24:20];
   assign f3  = w[14:12];
   assign f7  = w[31:25];

   // One adder serves jal and the branches; the immediate differs by format.
   assign target_sum = instr_in.instr_addr + ((opc == OPC_JAL) ? imm_j(w) : imm_b(w));

   // Classify the word and pick the fields that the operation uses.
   always_comb begin
      result_out = '0;
      unique case (opc)
         OPC_LUI: begin
            result_out.op_kind   = OP_LUI;
            result_out.dest_reg  = rd;
            result_out.immediate = {12'b0, w[31:12]};
         end
         OPC_AUIPC: begin
            result_out.op_kind   = OP_AUIPC;
            result_out.dest_reg  = rd;
            result_out.immediate = {12'b0, w[31:12]};
         end
         OPC_JAL: begin
            result_out.op_kind     = OP_JAL;
            result_out.dest_reg    = rd;
            result_out.immediate   = imm_j(w);
            result_out.target_addr = target_sum;
         end
         OPC_JALR: begin
            // Funct3 is not checked for jalr.
            result_out.op_kind   = OP_JALR;
            result_out.dest_reg  = rd;
            result_out.src_reg_a = rs1;
            result_out.immediate = imm_i(w);
         end
         OPC_BRANCH: begin
            unique case (f3)
               F3_0:    result_out.op_kind = OP_BEQ;
               F3_1:    result_out.op_kind = OP_BNE;
               F3_4:    result_out.op_kind = OP_BLT;
               F3_5:    result_out.op_kind = OP_BGE;
               F3_6:    result_out.op_kind = OP_BLTU;
               F3_7:    result_out.op_kind = OP_BGEU;
               default: result_out.op_kind = OP_ILLEGAL;
            endcase
            if (result_out.op_kind != OP_ILLEGAL) begin
               result_out.src_reg_a   = rs1;
               result_out.src_reg_b   = rs2;
               result_out.immediate   = imm_b(w);
               result_out.target_addr = target_sum;
            end
         end
         OPC_LOAD: begin
            unique case (f3)
               F3_0:    result_out.op_kind = OP_LB;
               F3_1:    result_out.op_kind = OP_LH;
               F3_2:    result_out.op_kind = OP_LW;
               F3_4:    result_out.op_kind = OP_LBU;
               F3_5:    result_out.op_kind = OP_LHU;
               default: result_out.op_kind = OP_ILLEGAL;
            endcase
            if (result_out.op_kind != OP_ILLEGAL) begin
               result_out.dest_reg  = rd;
               result_out.src_reg_a = rs1;
               result_out.immediate = imm_i(w);
            end
         end
         OPC_STORE: begin
            unique case (f3)
               F3_0:    result_out.op_kind = OP_SB;
               F3_1:    result_out.op_kind = OP_SH;
               F3_2:    result_out.op_kind = OP_SW;
               default: result_out.op_kind = OP_ILLEGAL;
            endcase
            if (result_out.op_kind != OP_ILLEGAL) begin
               result_out.src_reg_a = rs1;
               result_out.src_reg_b = rs2;
               result_out.immediate = imm_s(w);
            end
         end
         OPC_OP_IMM: begin
            unique case (f3)
               F3_0: result_out.op_kind = OP_ADDI;
               F3_1: result_out.op_kind = (f7 == F7_BASE) ? OP_SLLI : OP_ILLEGAL;
               F3_2: result_out.op_kind = OP_SLTI;
               F3_3: result_out.op_kind = OP_SLTIU;
               F3_4: result_out.op_kind = OP_XORI;
               F3_5: begin
                  if (f7 == F7_BASE) begin
                     result_out.op_kind = OP_SRLI;
                  end else if (f7 == F7_ALT) begin
                     result_out.op_kind = OP_SRAI;
                  end else begin
                     result_out.op_kind = OP_ILLEGAL;
                  end
               end
               F3_6: result_out.op_kind = OP_ORI;
               F3_7: result_out.op_kind = OP_ANDI;
            endcase
            if (result_out.op_kind != OP_ILLEGAL) begin
               result_out.dest_reg  = rd;
               result_out.src_reg_a = rs1;
               // Shifts carry the shift amount instead of the I immediate.
               result_out.immediate = (f3 == F3_1 || f3 == F3_5) ? {27'b0, rs2} : imm_i(w);
            end
         end
         OPC_OP: begin
            if (f7 == F7_BASE) begin
               unique case (f3)
                  F3_0: result_out.op_kind = OP_ADD;
                  F3_1: result_out.op_kind = OP_SLL;
                  F3_2: result_out.op_kind = OP_SLT;
                  F3_3: result_out.op_kind = OP_SLTU;
                  F3_4: result_out.op_kind = OP_XOR;
                  F3_5: result_out.op_kind = OP_SRL;
                  F3_6: result_out.op_kind = OP_OR;
                  F3_7: result_out.op_kind = OP_AND;
               endcase
            end else if (f7 == F7_ALT && f3 == F3_0) begin
               result_out.op_kind = OP_SUB;
            end else if (f7 == F7_ALT && f3 == F3_5) begin
               result_out.op_kind = OP_SRA;
            end
            if (result_out.op_kind != OP_ILLEGAL) begin
               result_out.dest_reg  = rd;
               result_out.src_reg_a = rs1;
               result_out.src_reg_b = rs2;
            end
         end
         OPC_SYSTEM: begin
            if (w == WORD_ECALL) begin
               result_out.op_kind = OP_ECALL;
            end else if (w == WORD_EBREAK) begin
               result_out.op_kind = OP_EBREAK;
            end else begin
               unique case (f3)
                  F3_1:    result_out.op_kind = OP_CSRRW;
                  F3_2:    result_out.op_kind = OP_CSRRS;
                  F3_3:    result_out.op_kind = OP_CSRRC;
                  F3_5:    result_out.op_kind = OP_CSRRWI;
                  F3_6:    result_out.op_kind = OP_CSRRSI;
                  F3_7:    result_out.op_kind = OP_CSRRCI;
                  default: result_out.op_kind = OP_ILLEGAL;
               endcase
               if (result_out.op_kind != OP_ILLEGAL) begin
                  result_out.dest_reg   = rd;
                  result_out.csr_number = w[31:20];
                  // The immediate forms carry zimm where rs1 would be.
                  if (f3[2]) begin
                     result_out.immediate = {27'b0, rs1};
                  end else begin
                     result_out.src_reg_a = rs1;
                  end
               end
            end
         end
         default: result_out = '0;
      endcase
   end

endmodule
